// ----- rtl/core/ibs_pkg.sv -----
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared types, codes and phase tables of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package ibs_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam logic [CFG_WIDTH-1:0] PHASE_CYCLES_RESET = 16'd64;

	// command opcodes
	localparam logic [2:0] OPC_START = 3'd0;
	localparam logic [2:0] OPC_STOP  = 3'd1;
	localparam logic [2:0] OPC_WRITE = 3'd2;
	localparam logic [2:0] OPC_READ  = 3'd3;
	localparam logic [2:0] OPC_WACK  = 3'd4;
	localparam logic [2:0] OPC_ACK   = 3'd5;
	localparam logic [2:0] OPC_NACK  = 3'd6;
	localparam logic [2:0] OPC_PROBE = 3'd7;

	// last sub-sequence of a probe
	localparam logic [1:0] PROBE_LAST = 2'd3;
	// last bit phase of a byte
	localparam logic [3:0] BYTE_LAST_PHASE = 4'd15;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_START = 4'd1,
		ST_STOP  = 4'd2,
		ST_WRITE = 4'd3,
		ST_READ  = 4'd4,
		ST_WACK  = 4'd5,
		ST_ACK   = 4'd6,
		ST_NACK  = 4'd7,
		ST_PROBE = 4'd8
	} seq_state_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       sda_in;
		logic       scl_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       nack;
		logic       bus_error;
	} res_t;

	// drive pair passed between the leave and enter logic
	typedef struct packed {
		logic scl;
		logic sda;
	} drive_t;

	// number of phases of each basic sequence
	function automatic logic [4:0] phase_count(input seq_state_t op);
		logic [4:0] n;
		unique case (op)
			ST_START, ST_STOP, ST_WACK, ST_NACK: n = 5'd3;
			ST_WRITE, ST_READ:                   n = 5'd16;
			ST_ACK:                              n = 5'd4;
			default:                             n = 5'd0;
		endcase
		return n;
	endfunction

	// sequence run at each step of a probe
	function automatic seq_state_t probe_op(input logic [1:0] step);
		seq_state_t op;
		unique case (step)
			2'd0:    op = ST_START;
			2'd1:    op = ST_WRITE;
			2'd2:    op = ST_WACK;
			default: op = ST_STOP;
		endcase
		return op;
	endfunction

	// drive levels set on the first clock of a phase
	function automatic drive_t enter_drives(input seq_state_t op, input logic [3:0] idx,
			input logic msb, input drive_t cur);
		drive_t d;
		d = cur;
		unique case (op)
			ST_START: begin
				if (idx == 4'd0) begin
					d.sda = 1'b1;
					d.scl = 1'b1;
				end else if (idx == 4'd1) d.sda = 1'b0;
				else d.scl = 1'b0;
			end
			ST_STOP: begin
				if (idx == 4'd0) d.sda = 1'b0;
				else if (idx == 4'd1) d.scl = 1'b1;
				else d.sda = 1'b1;
			end
			ST_WRITE: begin
				if (!idx[0]) d.sda = msb;
				else d.scl = 1'b1;
			end
			ST_READ: begin
				if (!idx[0]) d.scl = 1'b1;
			end
			ST_WACK: begin
				if (idx == 4'd0) d.sda = 1'b1;
				else if (idx == 4'd1) d.scl = 1'b1;
			end
			ST_ACK: begin
				if (idx == 4'd0) d.sda = 1'b0;
				else if (idx == 4'd1) d.scl = 1'b1;
				else if (idx == 4'd2) d.scl = 1'b0;
				else d.sda = 1'b1;
			end
			ST_NACK: begin
				if (idx == 4'd0) d.sda = 1'b1;
				else if (idx == 4'd1) d.scl = 1'b1;
				else d.scl = 1'b0;
			end
			default: d = cur;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/core/ibs_channels.sv -----
// ----------------------------------------------------------------------------
// ibs_channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ibs_cmd_if;
	logic        valid;
	logic        ready;
	ibs_pkg::cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ibs_res_if;
	logic        valid;
	logic        ready;
	ibs_pkg::res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/ibs_in_stage.sv -----
// ----------------------------------------------------------------------------
// ibs_in_stage
// Input register: holds one command item until the sequencer takes it.
// ----------------------------------------------------------------------------
module ibs_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	ibs_cmd_if.sink       cmd_ch,
	input  logic          pop,
	output logic          valid_s1,
	output ibs_pkg::cmd_t item_s1
);

	// free when empty or emptied in this cycle
	assign cmd_ch.ready = !valid_s1 || pop;

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	// payload capture on transfer
	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			item_s1 <= cmd_ch.payload;
		end
	end

endmodule

// ----- rtl/core/ibs_core.sv -----
// ----------------------------------------------------------------------------
// ibs_core
// Sequencer state and the single-step logic that advances it per item.
// ----------------------------------------------------------------------------
module ibs_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ibs_pkg::CFG_WIDTH-1:0]   cfg_wdata,
	input  logic                            step_en,
	input  ibs_pkg::cmd_t                   item,
	output ibs_pkg::res_t                   res
);

	ibs_pkg::seq_state_t                  state_q, state_d;
	logic [ibs_pkg::TIMER_WIDTH-1:0]      timer_q, timer_d, timer_load;
	logic [ibs_pkg::CFG_WIDTH-1:0]        phase_cycles_q;
	logic [3:0]                           bit_q, bit_d;
	logic [1:0]                           probe_q, probe_d;
	logic [7:0]                           shift_q, shift_d;
	logic [7:0]                           rx_q, rx_d;
	logic                                 ack_q, ack_d;
	logic                                 err_q, err_d;
	ibs_pkg::drive_t                      drv_q, drv_d;
	logic                                 done;

	ibs_pkg::seq_state_t                  op, enter_op, cmd_op;
	logic [3:0]                           enter_idx;
	logic                                 enter_en;
	logic                                 busy, tick, last_phase, more_probe;
	logic                                 start_cmd, is_probe, bus_idle;

	// phase length, zero acts as one
	assign timer_load = (phase_cycles_q == '0) ? '0 :
		ibs_pkg::TIMER_WIDTH'(phase_cycles_q - 1'b1);

	// decode of the current step
	assign busy       = (state_q != ibs_pkg::ST_IDLE);
	assign op         = (state_q == ibs_pkg::ST_PROBE) ? ibs_pkg::probe_op(probe_q) : state_q;
	assign tick       = busy && (timer_q == '0);
	assign last_phase = ({1'b0, bit_q} + 5'd1) >= ibs_pkg::phase_count(op);
	assign more_probe = (state_q == ibs_pkg::ST_PROBE) && (probe_q != ibs_pkg::PROBE_LAST);
	assign start_cmd  = !busy && item.cmd_valid;
	assign is_probe   = (item.opcode == ibs_pkg::OPC_PROBE);
	assign bus_idle   = item.sda_in && item.scl_in;
	assign cmd_op     = ibs_pkg::seq_state_t'({1'b0, item.opcode} + 4'd1);

	// which phase gets entered in this step
	always_comb begin
		enter_en  = 1'b0;
		enter_op  = op;
		enter_idx = 4'd0;
		priority if (tick && !last_phase) begin
			enter_en  = 1'b1;
			enter_idx = bit_q + 4'd1;
		end else if (tick && more_probe) begin
			enter_en = 1'b1;
			enter_op = ibs_pkg::probe_op(probe_q + 2'd1);
		end else if (start_cmd && is_probe) begin
			enter_en = bus_idle;
			enter_op = ibs_pkg::ST_START;
		end else if (start_cmd) begin
			enter_en = 1'b1;
			enter_op = cmd_op;
		end else begin
			enter_en = 1'b0;
		end
	end

	// next state of the sequencer control
	always_comb begin
		state_d = state_q;
		timer_d = timer_q;
		bit_d   = bit_q;
		probe_d = probe_q;
		done    = 1'b0;
		if (busy) begin
			if (!tick) begin
				timer_d = timer_q - 1'b1;
			end else if (!last_phase) begin
				bit_d = bit_q + 4'd1;
			end else begin
				bit_d = 4'd0;
				if (more_probe) begin
					probe_d = probe_q + 2'd1;
				end else begin
					state_d = ibs_pkg::ST_IDLE;
					probe_d = 2'd0;
					done    = 1'b1;
				end
			end
		end else if (item.cmd_valid) begin
			bit_d   = 4'd0;
			probe_d = 2'd0;
			if (is_probe) begin
				if (bus_idle) state_d = ibs_pkg::ST_PROBE;
				else done = 1'b1;
			end else begin
				state_d = cmd_op;
			end
		end
		if (enter_en) timer_d = timer_load;
	end

	// bus drives, shifter and status
	always_comb begin
		drv_d   = drv_q;
		shift_d = shift_q;
		rx_d    = rx_q;
		ack_d   = ack_q;
		err_d   = err_q;
		// end of phase actions
		if (tick) begin
			if (op == ibs_pkg::ST_WRITE && bit_q[0]) begin
				drv_d.scl = 1'b0;
				shift_d   = {shift_q[6:0], 1'b0};
				if (bit_q == ibs_pkg::BYTE_LAST_PHASE) drv_d.sda = 1'b1;
			end else if (op == ibs_pkg::ST_READ && !bit_q[0]) begin
				shift_d   = {shift_q[6:0], item.sda_in};
				drv_d.scl = 1'b0;
			end else if (op == ibs_pkg::ST_WACK && bit_q == 4'd1) begin
				ack_d     = item.sda_in;
				drv_d.scl = 1'b0;
			end
			if (last_phase && op == ibs_pkg::ST_READ) rx_d = shift_d;
		end
		// new command
		if (start_cmd) begin
			err_d = 1'b0;
			if (is_probe) begin
				if (bus_idle) begin
					shift_d = item.tx_byte;
				end else begin
					err_d = 1'b1;
					ack_d = 1'b1;
				end
			end else begin
				shift_d = (cmd_op == ibs_pkg::ST_WRITE) ? item.tx_byte : 8'd0;
			end
		end
		// start of phase drives
		if (enter_en) drv_d = ibs_pkg::enter_drives(enter_op, enter_idx, shift_d[7], drv_d);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibs_pkg::ST_IDLE;
			timer_q <= '0;
			bit_q   <= 4'd0;
			probe_q <= 2'd0;
			shift_q <= 8'd0;
			rx_q    <= 8'd0;
			ack_q   <= 1'b1;
			err_q   <= 1'b0;
			drv_q   <= '{scl: 1'b1, sda: 1'b1};
		end else if (step_en) begin
			state_q <= state_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
			probe_q <= probe_d;
			shift_q <= shift_d;
			rx_q    <= rx_d;
			ack_q   <= ack_d;
			err_q   <= err_d;
			drv_q   <= drv_d;
		end
	end

	// phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_cycles_q <= ibs_pkg::PHASE_CYCLES_RESET;
		end else if (cfg_we) begin
			phase_cycles_q <= cfg_wdata;
		end
	end

	// result of this step
	always_comb begin
		res.scl_out   = drv_d.scl;
		res.sda_out   = drv_d.sda;
		res.busy_res  = (state_d != ibs_pkg::ST_IDLE);
		res.done_res  = done;
		res.rx_byte   = rx_d;
		res.nack      = ack_d;
		res.bus_error = err_d;
	end

endmodule

// ----- rtl/core/ibs_out_stage.sv -----
// ----------------------------------------------------------------------------
// ibs_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module ibs_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ibs_pkg::res_t res,
	output logic          space,
	ibs_res_if.source     res_ch
);

	logic          valid_q;
	ibs_pkg::res_t data_q;

	// room when empty or drained in this cycle
	assign space = !valid_q || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign res_ch.valid   = valid_q;
	assign res_ch.payload = data_q;

endmodule

// ----- rtl/core/i2c_master_bit_sequencer.sv -----
// A command item is held in the input register, and its result in the result register.
// One item per cycle while the result register has room; each register holds one transfer.
// Each item advances the phase timer and sequencer by exactly one clock step.
// Reset (arst_n low, asynchronous): sequencer idle, both lines released, nack set,
// phase length back to PHASE_CYCLES_RESET, both channel registers empty.
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master that bit-bangs start, stop, byte, acknowledge and probe sequences.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ibs_pkg::CFG_WIDTH-1:0] cfg_wdata,
	ibs_cmd_if.sink                       cmd_ch,
	ibs_res_if.source                     res_ch
);

	logic          valid_s1;
	ibs_pkg::cmd_t item_s1;
	ibs_pkg::res_t res;
	logic          space;
	logic          step_en;

	// one sequencer step per item moved to the result register
	assign step_en = valid_s1 && space;

	ibs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_ch   (cmd_ch),
		.pop      (step_en),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ibs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step_en   (step_en),
		.item      (item_s1),
		.res       (res)
	);

	ibs_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step_en),
		.res    (res),
		.space  (space),
		.res_ch (res_ch)
	);

endmodule

// ----- rtl/core/ibs_checker.sv -----
// ----------------------------------------------------------------------------
// ibs_checker
// Port-level checks of the I2C master bit sequencer result stream.
// ----------------------------------------------------------------------------
module ibs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input ibs_pkg::res_t res_payload
);

	// a finished command leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.done_res |-> !res_payload.busy_res)
		else $error("done with busy still set");

	// a refused probe always reports no acknowledge
	a_err_nack: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.bus_error |-> res_payload.nack)
		else $error("bus error without nack");

	// a stalled result transfer holds its content
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_payload))
		else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer ibs_checker u_ibs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_ch.valid),
	.res_ready   (res_ch.ready),
	.res_payload (res_ch.payload)
);
